/* design/assert_macros.svh */
// assertion macros shared by the console writer rtl
// no dependencies; taken in by include in the files that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TCW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TCW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tcw_pkg.sv */
// types, codes and constants of the text console writer
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package tcw_pkg;

    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 25;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam int CELL_W     = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_FG = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_BG = 1'b1;

    localparam logic [3:0] RESET_FG = 4'd2;
    localparam logic [3:0] RESET_BG = 4'd15;

    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // request kinds
    typedef logic [2:0] req_t;
    localparam req_t REQ_PUT     = 3'd0;
    localparam req_t REQ_BACK    = 3'd1;
    localparam req_t REQ_CLEAR   = 3'd2;
    localparam req_t REQ_GOTO    = 3'd3;
    localparam req_t REQ_REPAINT = 3'd4;
    localparam req_t REQ_READ    = 3'd5;

    // sweep counter operations
    typedef logic [2:0] cnt_op_t;
    localparam cnt_op_t CNT_HOLD = 3'd0;
    localparam cnt_op_t CNT_INC  = 3'd1;
    localparam cnt_op_t CNT_ZERO = 3'd2;
    localparam cnt_op_t CNT_COLS = 3'd3;
    localparam cnt_op_t CNT_LAST = 3'd4;

    // screen memory read operations
    typedef logic [1:0] rd_op_t;
    localparam rd_op_t RD_NONE = 2'd0;
    localparam rd_op_t RD_CNT  = 2'd1;
    localparam rd_op_t RD_CUR  = 2'd2;
    localparam rd_op_t RD_POS  = 2'd3;

    // screen memory write operations
    typedef logic [2:0] wr_op_t;
    localparam wr_op_t WR_NONE        = 3'd0;
    localparam wr_op_t WR_BLANK       = 3'd1;
    localparam wr_op_t WR_RESET_BLANK = 3'd2;
    localparam wr_op_t WR_CHAR        = 3'd3;
    localparam wr_op_t WR_COPY        = 3'd4;
    localparam wr_op_t WR_RECOLOR     = 3'd5;
    localparam wr_op_t WR_BACK        = 3'd6;

    // write position operations
    typedef logic [2:0] pos_op_t;
    localparam pos_op_t POS_HOLD    = 3'd0;
    localparam pos_op_t POS_NEWLINE = 3'd1;
    localparam pos_op_t POS_ADVANCE = 3'd2;
    localparam pos_op_t POS_BACK    = 3'd3;
    localparam pos_op_t POS_GOTO    = 3'd4;

    typedef struct packed {
        logic    load;
        cnt_op_t cnt_op;
        rd_op_t  rd_op;
        wr_op_t  wr_op;
        pos_op_t pos_op;
        logic    cap;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        req_t req_type;
        logic is_nl;
        logic col_zero;
        logic col_wrap;
        logic row_last;
        logic cnt_end;
        logic cnt_last;
    } sts_t;

endpackage

`default_nettype wire

/* design/tcw_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/tcw_ctrl.sv */
// request sequencer of the text console writer
// depends on tcw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tcw_ctrl import tcw_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output      logic s_ready,
    output      logic m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output      cmd_t cmd
);

    localparam logic [3:0] ST_INIT        = 4'd0;
    localparam logic [3:0] ST_IDLE        = 4'd1;
    localparam logic [3:0] ST_DECODE      = 4'd2;
    localparam logic [3:0] ST_NEWLINE     = 4'd3;
    localparam logic [3:0] ST_SCROLL_HEAD = 4'd4;
    localparam logic [3:0] ST_SCROLL      = 4'd5;
    localparam logic [3:0] ST_FILL        = 4'd6;
    localparam logic [3:0] ST_PUT         = 4'd7;
    localparam logic [3:0] ST_BACK_RD     = 4'd8;
    localparam logic [3:0] ST_BACK_WR     = 4'd9;
    localparam logic [3:0] ST_PAINT_HEAD  = 4'd10;
    localparam logic [3:0] ST_PAINT       = 4'd11;
    localparam logic [3:0] ST_READ_WAIT   = 4'd12;
    localparam logic [3:0] ST_DONE        = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;
    logic       put_after;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign out_free  = !m_valid_reg || m_ready;
    // a printable character still has to be written after the line break
    assign put_after = (sts.req_type == REQ_PUT) && !sts.is_nl;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.wr_op = WR_RESET_BLANK;
                if (sts.cnt_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.cnt_op = CNT_INC;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cmd.cnt_op = CNT_ZERO;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.req_type)
                    REQ_PUT: begin
                        if (sts.is_nl || sts.col_wrap) begin
                            state_next = ST_NEWLINE;
                        end else begin
                            state_next = ST_PUT;
                        end
                    end
                    REQ_BACK: begin
                        if (sts.col_zero) begin
                            state_next = ST_DONE;
                        end else begin
                            cmd.pos_op = POS_BACK;
                            state_next = ST_BACK_RD;
                        end
                    end
                    REQ_CLEAR: begin
                        state_next = ST_FILL;
                    end
                    REQ_GOTO: begin
                        cmd.pos_op = POS_GOTO;
                        state_next = ST_DONE;
                    end
                    REQ_REPAINT: begin
                        state_next = ST_PAINT_HEAD;
                    end
                    REQ_READ: begin
                        cmd.rd_op  = RD_POS;
                        state_next = ST_READ_WAIT;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_NEWLINE: begin
                cmd.pos_op = POS_NEWLINE;
                if (sts.row_last) begin
                    cmd.cnt_op = CNT_COLS;
                    state_next = ST_SCROLL_HEAD;
                end else if (put_after) begin
                    state_next = ST_PUT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_HEAD: begin
                cmd.rd_op  = RD_CNT;
                cmd.cnt_op = CNT_INC;
                state_next = ST_SCROLL;
            end
            ST_SCROLL: begin
                cmd.wr_op = WR_COPY;
                if (sts.cnt_end) begin
                    cmd.cnt_op = CNT_LAST;
                    state_next = ST_FILL;
                end else begin
                    cmd.rd_op  = RD_CNT;
                    cmd.cnt_op = CNT_INC;
                end
            end
            ST_FILL: begin
                cmd.wr_op = WR_BLANK;
                if (!sts.cnt_last) begin
                    cmd.cnt_op = CNT_INC;
                end else if (put_after) begin
                    state_next = ST_PUT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PUT: begin
                cmd.wr_op  = WR_CHAR;
                cmd.pos_op = POS_ADVANCE;
                state_next = ST_DONE;
            end
            ST_BACK_RD: begin
                cmd.rd_op  = RD_CUR;
                state_next = ST_BACK_WR;
            end
            ST_BACK_WR: begin
                cmd.wr_op  = WR_BACK;
                state_next = ST_DONE;
            end
            ST_PAINT_HEAD: begin
                cmd.rd_op  = RD_CNT;
                cmd.cnt_op = CNT_INC;
                state_next = ST_PAINT;
            end
            ST_PAINT: begin
                cmd.wr_op = WR_RECOLOR;
                if (sts.cnt_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_op  = RD_CNT;
                    cmd.cnt_op = CNT_INC;
                end
            end
            ST_READ_WAIT: begin
                cmd.cap    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `TCW_ASSERT_NOW(a_out_load_free, aclk, aresetn, cmd.out_load, out_free, "result overwritten before taken")
    `TCW_ASSERT_NXT(a_accept_decode, aclk, aresetn, s_valid && s_ready, state_reg == ST_DECODE, "accepted beat not decoded")

endmodule

`default_nettype wire

/* design/tcw_dp.sv */
// datapath of the text console writer: position, colours, sweep counter, screen ram
// depends on tcw_pkg, tcw_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tcw_dp import tcw_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire cmd_t                             cmd,
    output      sts_t                             sts,
    input  wire logic                             cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]            cfg_wdata,
    input  wire logic [2:0]                       req_type,
    input  wire logic [7:0]                       char_code,
    input  wire logic [$clog2(SCREEN_COLS+1)-1:0] pos_x,
    input  wire logic [$clog2(SCREEN_ROWS)-1:0]   pos_y,
    input  wire logic [3:0]                       paint_fg,
    input  wire logic [3:0]                       paint_bg,
    output      logic [7:0]                       cell_char,
    output      logic [7:0]                       cell_color,
    output      logic [$clog2(SCREEN_ROWS)-1:0]   cur_row,
    output      logic [$clog2(SCREEN_COLS+1)-1:0] cur_col
);

    localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(SCREEN_COLS + 1);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);

    localparam logic [COL_W-1:0]  COLS_C    = COL_W'(SCREEN_COLS);
    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(CELL_COUNT);
    localparam logic [CNT_W-1:0]  CNT_LASTV = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0]  CNT_COLSV = CNT_W'(SCREEN_COLS);
    localparam logic [CNT_W-1:0]  CNT_LROW  = CNT_W'(CELL_COUNT - SCREEN_COLS);

    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [2:0]        req_reg;
    logic [7:0]        char_reg;
    logic [7:0]        paint_reg;
    logic [COL_W-1:0]  goto_col_reg;
    logic [ROW_W-1:0]  goto_row_reg;
    logic [ADDR_W-1:0] rd_addr_d_reg;
    logic [CELL_W-1:0] rd_cell_reg;
    logic [7:0]        out_char_reg;
    logic [7:0]        out_color_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;

    logic [COL_W-1:0]  read_col;
    logic [COL_W-1:0]  addr_col;
    logic [ROW_W-1:0]  addr_row;
    logic [ADDR_W-1:0] pos_addr;
    logic [7:0]        text_color;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign text_color = {bg_reg, fg_reg};
    // a pending wrap reads the last column
    assign read_col   = (goto_col_reg == COLS_C) ? COL_MAX : goto_col_reg;
    assign addr_col   = (cmd.rd_op == RD_POS) ? read_col : col_reg;
    assign addr_row   = (cmd.rd_op == RD_POS) ? goto_row_reg : row_reg;
    assign pos_addr   = ADDR_W'(addr_row) * COLS_A + ADDR_W'(addr_col);

    assign sts.req_type = req_reg;
    assign sts.is_nl    = (char_reg == CHAR_NEWLINE);
    assign sts.col_zero = (col_reg == '0);
    assign sts.col_wrap = (col_reg == COLS_C);
    assign sts.row_last = (row_reg == ROW_MAX);
    assign sts.cnt_end  = (cnt_reg == CNT_END);
    assign sts.cnt_last = (cnt_reg == CNT_LASTV);

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_we && (cfg_addr == REG_TEXT_FG)) begin
            fg_next = cfg_wdata;
        end
        if (cfg_we && (cfg_addr == REG_TEXT_BG)) begin
            bg_next = cfg_wdata;
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        case (cmd.pos_op)
            POS_NEWLINE: begin
                col_next = '0;
                if (row_reg != ROW_MAX) begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            POS_ADVANCE: col_next = col_reg + COL_W'(1);
            POS_BACK:    col_next = col_reg - COL_W'(1);
            POS_GOTO: begin
                col_next = goto_col_reg;
                row_next = goto_row_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            CNT_INC:  cnt_next = cnt_reg + CNT_W'(1);
            CNT_ZERO: cnt_next = '0;
            CNT_COLS: cnt_next = CNT_COLSV;
            CNT_LAST: cnt_next = CNT_LROW;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (cmd.rd_op)
            RD_CNT: begin
                ram_re    = 1'b1;
                ram_raddr = cnt_reg[ADDR_W-1:0];
            end
            RD_CUR, RD_POS: begin
                ram_re    = 1'b1;
                ram_raddr = pos_addr;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        case (cmd.wr_op)
            WR_BLANK: begin
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = {text_color, CHAR_BLANK};
            end
            WR_RESET_BLANK: begin
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = {RESET_BG, RESET_FG, CHAR_BLANK};
            end
            WR_CHAR: begin
                ram_waddr = pos_addr;
                ram_wdata = {text_color, char_reg};
            end
            WR_COPY: begin
                // the row below moves up one row
                ram_waddr = rd_addr_d_reg - COLS_A;
                ram_wdata = ram_rdata;
            end
            WR_RECOLOR: begin
                ram_waddr = rd_addr_d_reg;
                ram_wdata = {paint_reg, ram_rdata[7:0]};
            end
            WR_BACK: begin
                ram_waddr = rd_addr_d_reg;
                ram_wdata = {ram_rdata[15:8], CHAR_BLANK};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELL_COUNT)
    ) u_screen (
        .clk    (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg  <= RESET_FG;
            bg_reg  <= RESET_BG;
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end else begin
            fg_reg  <= fg_next;
            bg_reg  <= bg_next;
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg      <= req_type;
            char_reg     <= char_code;
            paint_reg    <= {paint_bg, paint_fg};
            goto_col_reg <= (pos_x > COLS_C) ? COLS_C : pos_x;
            goto_row_reg <= (pos_y > ROW_MAX) ? ROW_MAX : pos_y;
        end
        if (ram_re) begin
            rd_addr_d_reg <= ram_raddr;
        end
        if (cmd.cap) begin
            rd_cell_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            out_char_reg  <= (req_reg == REQ_READ) ? rd_cell_reg[7:0] : 8'h00;
            out_color_reg <= (req_reg == REQ_READ) ? rd_cell_reg[15:8] : 8'h00;
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
        end
    end

    assign cell_char  = out_char_reg;
    assign cell_color = out_color_reg;
    assign cur_row    = out_row_reg;
    assign cur_col    = out_col_reg;

    `TCW_ASSERT_NOW(a_col_range, aclk, aresetn, 1'b1, (col_reg <= COLS_C) && (row_reg <= ROW_MAX), "write position off screen")
    `TCW_ASSERT_NOW(a_put_in_row, aclk, aresetn, cmd.wr_op == WR_CHAR, col_reg < COLS_C, "character written past last column")

endmodule

`default_nettype wire

/* design/text_console_writer.sv */
// text console writer: one result beat per request beat, one request at a time
// a put taking a pending wrap adds a newline step; a backspace at column zero skips its read
// and write; a held result beat stalls the next request in its last step; clear screen,
// repaint and newline on the last row walk the screen ram, a cell a cycle; after reset
// a clearing pass writes every cell with s_ready low; configuration writes are taken
// throughout
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // configuration write port: text_fg at index 0, text_bg at index 1
    input  wire logic                             cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]            cfg_wdata,

    // request beats
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic [2:0]                       s_req_type,
    input  wire logic [7:0]                       s_char_code,
    input  wire logic [$clog2(SCREEN_COLS+1)-1:0] s_pos_x,
    input  wire logic [$clog2(SCREEN_ROWS)-1:0]   s_pos_y,
    input  wire logic [3:0]                       s_paint_fg,
    input  wire logic [3:0]                       s_paint_bg,

    // result beats: cell read and write position after the request
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [7:0]                       m_cell_char,
    output      logic [7:0]                       m_cell_color,
    output      logic [$clog2(SCREEN_ROWS)-1:0]   m_cur_row,
    output      logic [$clog2(SCREEN_COLS+1)-1:0] m_cur_col
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: one state per step of a request; the result waits in the
    // datapath output register, so a new request is taken while it is held
    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: colour registers, write position, sweep counter and the
    // screen ram; scrolling copies each cell one row up, a cell a cycle
    tcw_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .req_type   (s_req_type),
        .char_code  (s_char_code),
        .pos_x      (s_pos_x),
        .pos_y      (s_pos_y),
        .paint_fg   (s_paint_fg),
        .paint_bg   (s_paint_bg),
        .cell_char  (m_cell_char),
        .cell_color (m_cell_color),
        .cur_row    (m_cur_row),
        .cur_col    (m_cur_col)
    );

endmodule

`default_nettype wire
